[hdl/mcb_pkg.sv]
package mcb_pkg;

    localparam int FRAC_BITS_DEF = 24;
    localparam int STEP_BITS_DEF = 16;

    localparam logic [30:0] INV_LN2_Q30 = 31'd1549082005;
    localparam logic [29:0] LN2_Q30     = 30'd744261118;
    localparam logic [62:0] SUM_MAX     = {63{1'b1}};

    typedef enum logic [2:0] {
        REG_LOG_SPOT    = 3'd0,
        REG_LOG_BARRIER = 3'd1,
        REG_STRIKE      = 3'd2,
        REG_DRIFT       = 3'd3,
        REG_VOL         = 3'd4,
        REG_STEPS       = 3'd5,
        REG_IS_CALL     = 3'd6,
        REG_ANTITHETIC  = 3'd7
    } cfg_reg_t;

    // Finished path handed from the front part to the back part.
    typedef struct packed {
        logic signed [31:0] lp_main;
        logic signed [31:0] lp_mirror;
        logic               knock_main;
        logic               knock_mirror;
    } path_end_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_MUL,
        BK_POLY,
        BK_DIV,
        BK_FIX,
        BK_NEXT,
        BK_OUT
    } back_state_t;

endpackage

[hdl/mcb_front.sv]
module mcb_front
    import mcb_pkg::*;
#(
    parameter int STEP_BITS = STEP_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic signed [15:0]   sample,
    input  logic signed [31:0]   log_spot,
    input  logic signed [31:0]   log_barrier,
    input  logic signed [31:0]   drift,
    input  logic        [30:0]   vol,
    input  logic        [15:0]   steps,
    input  logic                 is_call,
    output logic                 end_valid,
    input  logic                 end_ready,
    output path_end_t            end_data
);

    logic                 phase_reg, phase_next;
    logic signed [34:0]   term_reg;
    logic signed [31:0]   lpm_reg, lpr_reg;
    logic                 km_reg, kr_reg;
    logic [STEP_BITS-1:0] idx_reg;
    logic signed [47:0]   prod;
    logic signed [47:0]   term_full;
    logic signed [36:0]   sum_m, sum_r;
    logic signed [31:0]   base_m, base_r, new_m, new_r;
    logic                 knm, knr, bm, br, last;
    logic [STEP_BITS-1:0] steps_m;
    logic [STEP_BITS:0]   idx_inc;

    // Phase 0 takes the sample and forms the volatility term; phase 1 updates the paths.
    assign in_ready = !phase_reg;
    assign prod      = $signed({1'b0, vol}) * $signed({{16{sample[15]}}, sample});
    assign term_full = (prod + 48'sd2048) >>> 12;

    function automatic logic signed [31:0] sat32(input logic signed [36:0] v);
        if (v > 37'sd2147483647)        return 32'h7FFFFFFF;
        else if (v < -37'sd2147483648)  return 32'h80000000;
        else                            return v[31:0];
    endfunction

    always_comb begin
        steps_m = STEP_BITS'(steps);
        if (steps_m == '0) steps_m = {{(STEP_BITS-1){1'b0}}, 1'b1};
        base_m = (idx_reg == '0) ? log_spot : lpm_reg;
        base_r = (idx_reg == '0) ? log_spot : lpr_reg;
        bm     = (idx_reg == '0) ? 1'b0 : km_reg;
        br     = (idx_reg == '0) ? 1'b0 : kr_reg;
        sum_m  = 37'(base_m) + 37'(drift) + 37'(term_reg);
        sum_r  = 37'(base_r) + 37'(drift) - 37'(term_reg);
        new_m  = sat32(sum_m);
        new_r  = sat32(sum_r);
        knm    = bm | (is_call ? (new_m >= log_barrier) : (new_m <= log_barrier));
        knr    = br | (is_call ? (new_r >= log_barrier) : (new_r <= log_barrier));
        idx_inc = {1'b0, idx_reg} + 1'b1;
        last   = (idx_inc >= {1'b0, steps_m}) || (knm && knr);
        phase_next = phase_reg;
        if (!phase_reg && in_valid) phase_next = 1'b1;
        else if (phase_reg && (!last || end_ready)) phase_next = 1'b0;
    end

    assign end_valid = phase_reg && last;
    assign end_data  = '{lp_main: new_m, lp_mirror: new_r, knock_main: knm,
                         knock_mirror: knr};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= 1'b0;
            idx_reg   <= '0;
            lpm_reg   <= '0;
            lpr_reg   <= '0;
            km_reg    <= 1'b0;
            kr_reg    <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            if (phase_reg && (!last || end_ready)) begin
                lpm_reg <= new_m;
                lpr_reg <= new_r;
                km_reg  <= knm;
                kr_reg  <= knr;
                idx_reg <= last ? '0 : idx_inc[STEP_BITS-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!phase_reg && in_valid) term_reg <= term_full[34:0];
    end

endmodule

[hdl/mcb_queue.sv]
module mcb_queue
    import mcb_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      wr_valid,
    output logic      wr_ready,
    input  path_end_t wr_data,
    output logic      rd_valid,
    input  logic      rd_ready,
    output path_end_t rd_data
);

    // Two-entry queue between the front and back parts.
    path_end_t  mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       wr, rd;

    assign wr_ready = cnt_reg != 2'd2;
    assign rd_valid = cnt_reg != 2'd0;
    assign rd_data  = mem_reg[rp_reg];
    assign wr = wr_valid && wr_ready;
    assign rd = rd_valid && rd_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (wr) wp_reg <= !wp_reg;
            if (rd) rp_reg <= !rp_reg;
            cnt_reg <= cnt_reg + {1'b0, wr} - {1'b0, rd};
        end
    end

    always_ff @(posedge aclk) begin
        if (wr) mem_reg[wp_reg] <= wr_data;
    end

endmodule

[hdl/mcb_back.sv]
module mcb_back
    import mcb_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        q_valid,
    output logic        q_ready,
    input  path_end_t   q_data,
    input  logic [31:0] strike,
    input  logic        is_call,
    input  logic        antithetic,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] out_payoff,
    output logic [62:0] out_sum,
    output logic [31:0] out_count
);

    back_state_t          state_reg, state_next;
    path_end_t            job_reg;
    logic                 leg_reg;
    logic [2:0]           k_reg;
    logic signed [62:0]   prod_reg;
    logic [29:0]          u_reg;
    logic [31:0]          acc_reg;
    logic [30:0]          a_reg;
    logic [30:0]          q_reg;
    logic [31:0]          pay_a_reg;
    logic [62:0]          sum_reg;
    logic [31:0]          cnt_reg;
    logic [31:0]          pay_reg;
    logic signed [31:0]   x;
    logic signed [62:0]   t_full;
    logic signed [32:0]   t;
    logic signed [32-FRAC_BITS:0] n;
    logic [FRAC_BITS-1:0] f;
    logic [61:0]          uacc;
    logic [64:0]          recip_prod;
    logic [33:0]          rem;
    logic                 fix;
    logic [31:0]          price, leg_pay;
    logic                 knocked;
    logic [32:0]          avg_sum;
    logic [31:0]          pay_fin;
    logic [63:0]          sum_add;

    // floor(2^34 / k); the product with a dividend below 2^31 is at most one short.
    function automatic logic [33:0] recip(input logic [2:0] k);
        case (k)
            3'd2:    return 34'd8589934592;
            3'd3:    return 34'd5726623061;
            3'd4:    return 34'd4294967296;
            3'd5:    return 34'd3435973836;
            3'd6:    return 34'd2863311530;
            3'd7:    return 34'd2454267026;
            default: return 34'd0;
        endcase
    endfunction

    assign x          = leg_reg ? job_reg.lp_mirror : job_reg.lp_main;
    assign knocked    = leg_reg ? job_reg.knock_mirror : job_reg.knock_main;
    assign t_full     = prod_reg >>> 30;
    assign t          = t_full[32:0];
    assign n          = t[32:FRAC_BITS];
    assign f          = t[FRAC_BITS-1:0];
    assign uacc       = 62'(acc_reg) * 62'(u_reg);
    assign recip_prod = 65'(a_reg) * 65'(recip(k_reg));
    assign rem        = 34'(a_reg) - 34'(q_reg) * 34'(k_reg);
    assign fix        = rem >= 34'(k_reg);

    always_comb begin
        if (n >= 16)                price = 32'hFFFFFFFF;
        else if (n > 14)            price = acc_reg << (n - 14);
        else if (14 - n >= 31)      price = 32'd0;
        else                        price = acc_reg >> (14 - n);
        if (knocked)                leg_pay = 32'd0;
        else if (is_call)           leg_pay = (price > strike) ? price - strike : 32'd0;
        else                        leg_pay = (strike > price) ? strike - price : 32'd0;
        avg_sum = {1'b0, pay_a_reg} + {1'b0, leg_pay};
        pay_fin = (antithetic && leg_reg) ? avg_sum[32:1] : leg_pay;
        sum_add = {1'b0, sum_reg} + {32'd0, pay_fin};
    end

    always_comb begin
        state_next = state_reg;
        q_ready    = 1'b0;
        unique case (state_reg)
            BK_IDLE: if (q_valid) state_next = BK_MUL;
            BK_MUL:  state_next = BK_POLY;
            BK_POLY: state_next = BK_DIV;
            BK_DIV:  state_next = BK_FIX;
            BK_FIX:  state_next = (k_reg == 3'd1) ? BK_NEXT : BK_POLY;
            BK_NEXT: begin
                if (antithetic && !leg_reg) state_next = BK_MUL;
                else begin
                    state_next = BK_OUT;
                    q_ready    = 1'b1;
                end
            end
            BK_OUT:  if (out_ready) state_next = BK_IDLE;
            default: state_next = BK_IDLE;
        endcase
    end

    assign out_valid  = state_reg == BK_OUT;
    assign out_payoff = pay_reg;
    assign out_sum    = sum_reg;
    assign out_count  = cnt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= BK_IDLE;
            sum_reg   <= '0;
            cnt_reg   <= '0;
            leg_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == BK_IDLE && q_valid) leg_reg <= 1'b0;
            if (state_reg == BK_NEXT) begin
                if (antithetic && !leg_reg) leg_reg <= 1'b1;
                else begin
                    sum_reg <= sum_add[63] ? SUM_MAX : sum_add[62:0];
                    cnt_reg <= cnt_reg + 32'd1;
                end
            end
        end
    end

    // Exp: x*log2(e), split into integer and fraction, then seven Horner steps, each of
    // which multiplies, divides by k through its reciprocal and corrects by one.
    always_ff @(posedge aclk) begin
        case (state_reg)
            BK_IDLE: job_reg <= q_data;
            BK_MUL: begin
                u_reg   <= 30'((62'(f) * 62'(LN2_Q30)) >> FRAC_BITS);
                acc_reg <= 32'h40000000;
                k_reg   <= 3'd7;
            end
            BK_POLY: a_reg <= uacc[60:30];
            BK_DIV:  q_reg <= (k_reg == 3'd1) ? a_reg : recip_prod[64:34];
            BK_FIX: begin
                acc_reg <= 32'h40000000 + {1'b0, q_reg} + {31'd0, fix};
                k_reg   <= k_reg - 3'd1;
            end
            BK_NEXT: begin
                pay_a_reg <= leg_pay;
                pay_reg   <= pay_fin;
            end
            default: ;
        endcase
        if (state_next == BK_MUL)
            prod_reg <= 63'($signed(state_reg == BK_IDLE ?
                        (antithetic ? q_data.lp_main : q_data.lp_main) : job_reg.lp_mirror))
                        * 63'($signed({1'b0, INV_LN2_Q30}));
    end

endmodule

[hdl/mc_barrier_option_path_engine.sv]
// Front: forms the volatility term from a sample, then updates the path and tests the knock
// before it takes the next sample. A path end waits in a two-entry queue; the back part
// works out the exponential per leg (one multiply, then seven Horner steps), two legs if
// antithetic. The back part takes the next path end only once its result is accepted,
// and a full queue holds off the sample input.
// aresetn is synchronous, active low; clears path state, totals and registers to defaults.
module mc_barrier_option_path_engine
    import mcb_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int STEP_BITS = STEP_BITS_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [15:0]  s_tdata,   // normal_sample
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata,   // path_payoff, running_sum, paths_done, zero fill
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_data
);

    logic signed [31:0] log_spot_reg, log_barrier_reg, drift_reg;
    logic [31:0]        strike_reg;
    logic [30:0]        vol_reg;
    logic [15:0]        steps_reg;
    logic               is_call_reg, anti_reg;
    logic               e_valid, e_ready, q_valid, q_ready;
    path_end_t          e_data, q_data;
    logic [31:0]        payoff, count;
    logic [62:0]        sum;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            log_spot_reg    <= '0;
            log_barrier_reg <= '0;
            strike_reg      <= '0;
            drift_reg       <= '0;
            vol_reg         <= '0;
            steps_reg       <= 16'd1;
            is_call_reg     <= 1'b1;
            anti_reg        <= 1'b1;
        end else if (cfg_valid) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_LOG_SPOT:    log_spot_reg    <= cfg_data;
                REG_LOG_BARRIER: log_barrier_reg <= cfg_data;
                REG_STRIKE:      strike_reg      <= cfg_data;
                REG_DRIFT:       drift_reg       <= cfg_data;
                REG_VOL:         vol_reg         <= cfg_data[30:0];
                REG_STEPS:       steps_reg       <= cfg_data[15:0];
                REG_IS_CALL:     is_call_reg     <= cfg_data[0];
                REG_ANTITHETIC:  anti_reg        <= cfg_data[0];
                default: ;
            endcase
        end
    end

    mcb_front #(.STEP_BITS(STEP_BITS)) u_front (
        .aclk, .aresetn,
        .in_valid(s_tvalid), .in_ready(s_tready), .sample(s_tdata),
        .log_spot(log_spot_reg), .log_barrier(log_barrier_reg), .drift(drift_reg),
        .vol(vol_reg), .steps(steps_reg), .is_call(is_call_reg),
        .end_valid(e_valid), .end_ready(e_ready), .end_data(e_data)
    );

    mcb_queue u_queue (
        .aclk, .aresetn,
        .wr_valid(e_valid), .wr_ready(e_ready), .wr_data(e_data),
        .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_data)
    );

    mcb_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .aclk, .aresetn,
        .q_valid, .q_ready, .q_data,
        .strike(strike_reg), .is_call(is_call_reg), .antithetic(anti_reg),
        .out_valid(m_tvalid), .out_ready(m_tready),
        .out_payoff(payoff), .out_sum(sum), .out_count(count)
    );

    assign m_tdata = {1'b0, count, sum, payoff};

endmodule

[hdl/mcb_checker.sv]
module mcb_props (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [127:0] m_tdata
);

    property p_hold;
        @(posedge aclk) disable iff (!aresetn) m_tvalid && !m_tready |=> m_tvalid;
    endproperty
    a_hold: assert property (p_hold) else $error("result dropped while stalled");

    property p_stable;
        @(posedge aclk) disable iff (!aresetn) m_tvalid && !m_tready |=> $stable(m_tdata);
    endproperty
    a_stable: assert property (p_stable) else $error("result changed while stalled");

    property p_gap;
        @(posedge aclk) disable iff (!aresetn) s_tvalid && s_tready |=> !s_tready;
    endproperty
    a_gap: assert property (p_gap) else $error("sample accepted on consecutive cycles");

    property p_count;
        @(posedge aclk) disable iff (!aresetn)
            m_tvalid && m_tready ##1 m_tvalid |-> m_tdata[126:95] != $past(m_tdata[126:95]);
    endproperty
    a_count: assert property (p_count) else $error("path count did not advance");

endmodule

bind mc_barrier_option_path_engine mcb_props u_mcb_checker (
    .aclk, .aresetn, .s_tvalid, .s_tready, .m_tvalid, .m_tready, .m_tdata
);

[tb/mcb_checker.sv]
`timescale 1ns / 100ps

module mcb_checker
    import mcb_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [15:0]  s_tdata,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [127:0] m_tdata,
    input  logic         cfg_valid,
    input  logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_data,
    output int           mismatches,
    output int           awaiting
);

    typedef struct packed {
        logic [31:0] payoff;
        logic [62:0] total;
        logic [31:0] count;
    } path_result_t;

    path_result_t expected_paths[$];

    // Shadow copy of the registers.
    logic [31:0] spot_q, barrier_q, strike_q, drift_q;
    logic [30:0] vol_q;
    logic [15:0] steps_q;
    logic        call_q, anti_q;

    // Shadow copy of the path state.
    longint      lp_main, lp_mirror;
    logic        ko_main, ko_mirror;
    logic [15:0] step_cnt;
    logic [62:0] payoff_acc;
    logic [31:0] path_cnt;

    assign awaiting = expected_paths.size();

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // Log-price to Q16.16 price through base-two exponent and a Taylor series.
    function automatic logic [31:0] price_of(longint x);
        longint t, n;
        longint unsigned f, u, acc;
        t = (x * 64'sd1549082005) >>> 30;
        n = t >>> 24;
        f = longint'(t) & 64'hFF_FFFF;
        u = (f * 64'd744261118) >> 24;
        acc = 64'd1 << 30;
        for (int k = 7; k >= 1; k--)
            acc = (64'd1 << 30) + ((acc * u) >> 30) / k;
        if (n >= 16) return 32'hFFFF_FFFF;
        if (n > 14) return 32'(acc << (n - 14));
        if (14 - n >= 31) return 32'd0;
        return 32'(acc >> (14 - n));
    endfunction

    function automatic logic [31:0] leg_value(longint lp, logic ko);
        logic [31:0] price;
        if (ko) return 32'd0;
        price = price_of(lp);
        if (call_q) return (price > strike_q) ? price - strike_q : 32'd0;
        return (strike_q > price) ? strike_q - price : 32'd0;
    endfunction

    function automatic logic hits_barrier(longint lp);
        longint b;
        b = longint'(signed'(barrier_q));
        return call_q ? (lp >= b) : (lp <= b);
    endfunction

    task automatic advance_paths(logic [15:0] sample);
        longint z, term, drift;
        int unsigned limit;
        logic [32:0] pay;
        path_result_t r;
        z = longint'(signed'(sample));
        drift = longint'(signed'(drift_q));
        term = (longint'({1'b0, vol_q}) * z + 2048) >>> 12;
        limit = (steps_q == 0) ? 1 : steps_q;
        if (step_cnt == 0) begin
            lp_main = longint'(signed'(spot_q));
            lp_mirror = lp_main;
            ko_main = 1'b0;
            ko_mirror = 1'b0;
        end
        lp_main = clamp32(lp_main + drift + term);
        lp_mirror = clamp32(lp_mirror + drift - term);
        if (hits_barrier(lp_main)) ko_main = 1'b1;
        if (hits_barrier(lp_mirror)) ko_mirror = 1'b1;
        if (int'(step_cnt) + 1 < limit && !(ko_main && ko_mirror)) begin
            step_cnt = step_cnt + 1'b1;
            return;
        end
        step_cnt = '0;
        pay = {1'b0, leg_value(lp_main, ko_main)};
        if (anti_q) pay = (pay + leg_value(lp_mirror, ko_mirror)) >> 1;
        if (payoff_acc > SUM_MAX - 63'(pay)) payoff_acc = SUM_MAX;
        else payoff_acc = payoff_acc + 63'(pay);
        path_cnt = path_cnt + 1;
        r.payoff = pay[31:0];
        r.total = payoff_acc;
        r.count = path_cnt;
        expected_paths.push_back(r);
    endtask

    always @(posedge aclk) begin
        path_result_t want, got;
        if (!aresetn) begin
            spot_q = '0; barrier_q = '0; strike_q = '0; drift_q = '0; vol_q = '0;
            steps_q = 16'd1; call_q = 1'b1; anti_q = 1'b1;
            lp_main = 0; lp_mirror = 0; ko_main = 0; ko_mirror = 0;
            step_cnt = '0; payoff_acc = '0; path_cnt = '0;
            expected_paths.delete();
            mismatches <= 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_reg_t'(cfg_index))
                    REG_LOG_SPOT:    spot_q = cfg_data;
                    REG_LOG_BARRIER: barrier_q = cfg_data;
                    REG_STRIKE:      strike_q = cfg_data;
                    REG_DRIFT:       drift_q = cfg_data;
                    REG_VOL:         vol_q = cfg_data[30:0];
                    REG_STEPS:       steps_q = cfg_data[15:0];
                    REG_IS_CALL:     call_q = cfg_data[0];
                    REG_ANTITHETIC:  anti_q = cfg_data[0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) advance_paths(s_tdata);
            if (m_tvalid && m_tready) begin
                got.payoff = m_tdata[31:0];
                got.total = m_tdata[94:32];
                got.count = m_tdata[126:95];
                if (expected_paths.size() == 0) begin
                    if (mismatches < 10)
                        $display("%0t: unexpected result transaction %h", $realtime, m_tdata);
                    mismatches <= mismatches + 1;
                end else begin
                    want = expected_paths.pop_front();
                    if (got !== want || m_tdata[127] !== 1'b0) begin
                        if (mismatches < 10)
                            $display("%0t: payoff %h/%h sum %h/%h count %0d/%0d (exp/act)",
                                     $realtime, want.payoff, got.payoff, want.total,
                                     got.total, want.count, got.count);
                        mismatches <= mismatches + 1;
                    end
                end
            end
        end
    end

endmodule

[tb/tb.sv]
`timescale 1ns / 100ps

module tb;
    import mcb_pkg::*;

    localparam logic [31:0] LN100 = 32'd77261086;
    localparam logic [31:0] LN130 = 32'd81663550;
    localparam logic [31:0] LN70  = 32'd71278150;
    localparam logic [31:0] K100  = 32'd6553600;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [15:0]  s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [127:0] m_tdata;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [2:0]   cfg_index = '0;
    logic [31:0]  cfg_data = '0;
    int           mismatches, awaiting;

    int           send_idle_pct = 0;
    int           recv_stall_pct = 0;
    logic         hold_req = 1'b0;
    logic         hold_taken = 1'b0;
    int           hold_left = 0;

    always #1 aclk = ~aclk;

    mc_barrier_option_path_engine u_top (.*);

    mcb_checker u_chk (.*);

    // Long hold-off of the result side, counted here so the sender keeps going.
    always @(posedge aclk) begin
        if (hold_req && !hold_taken) begin
            hold_taken <= 1'b1;
            hold_left <= 600;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || hold_left > 0)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic load_regs(input logic [31:0] v [8]);
        for (int i = 0; i < 8; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= cfg_reg_t'(i);
            cfg_data <= v[i];
            do @(posedge aclk); while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic send_sample(input logic [15:0] z);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct && gap < 20) gap++;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= z;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic drain;
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (awaiting != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
    endtask

    task automatic set_idling(input int mode);
        case (mode % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 60; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 60; end
            default: begin send_idle_pct = 29; recv_stall_pct = 29; end
        endcase
    endtask

    logic [31:0] regs [8];
    logic [15:0] edge_samples [10] = '{16'h8000, 16'h7FFF, 16'h0000, 16'h0001, 16'hFFFF,
                                       16'h1000, 16'hF000, 16'h5555, 16'hAAAA, 16'h0800};
    initial begin
        logic [31:0] spot;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Near the money, call with an up barrier, single-step paths.
        regs = '{LN100, LN130, K100, 32'd0, 32'd335544, 32'd1, 32'd1, 32'd1};
        load_regs(regs);
        foreach (edge_samples[i]) send_sample(edge_samples[i]);
        drain();
        // Put with a down barrier, step count of zero, mirror not averaged.
        regs = '{LN100, LN70, K100, 32'hFFFF_0000, 32'd2000000, 32'd0, 32'd0, 32'd0};
        load_regs(regs);
        foreach (edge_samples[i]) send_sample(edge_samples[i]);
        drain();
        // Saturating log-prices and the widest volatility.
        regs = '{32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
                 32'h7FFF_FFFF, 32'd3, 32'd0, 32'd1};
        load_regs(regs);
        for (int i = 0; i < 6; i++) send_sample(edge_samples[i]);
        drain();
        // Very low spot flushes the exponential to zero; high barrier never hit.
        regs = '{32'h8000_0000, 32'h7FFF_FFFF, 32'd0, 32'h8000_0000, 32'd0, 32'd2, 32'd1, 32'd1};
        load_regs(regs);
        for (int i = 0; i < 4; i++) send_sample(edge_samples[i]);
        drain();
        // Longest step count, ended early when both paths knock out at once.
        regs = '{LN100, LN100 - 32'd100, K100, 32'd50000000, 32'd1000, 32'hFFFF, 32'd1, 32'd1};
        load_regs(regs);
        for (int i = 0; i < 4; i++) send_sample(16'($urandom));
        drain();

        for (int ph = 0; ph < 14; ph++) begin
            set_idling(ph);
            if (ph % 5 == 4) begin
                for (int i = 0; i < 8; i++) regs[i] = $urandom;
                regs[5] = $urandom_range(8);
            end else begin
                spot = LN100 + $urandom_range(8000000) - 32'd4000000;
                regs[0] = spot;
                regs[6] = $urandom_range(1);
                regs[1] = regs[6] ? spot + $urandom_range(9000000, 500000)
                                  : spot - $urandom_range(9000000, 500000);
                regs[2] = K100 + $urandom_range(1500000) - 32'd750000;
                regs[3] = $urandom_range(200000) - 32'd100000;
                regs[4] = $urandom_range(3000000);
                regs[5] = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(1, 8);
                regs[7] = $urandom_range(1);
            end
            if (ph == 6) hold_req <= 1'b1;
            load_regs(regs);
            for (int i = 0; i < 105; i++) send_sample(16'($urandom));
            drain();
        end

        if (mismatches == 0 && awaiting == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
